// ===== rtl/core/psd_pkg.sv =====
`timescale 1ns / 1ps

package psd_pkg;

  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;       // coordinate difference
  localparam int PROD_W     = 2 * DIFF_W;           // product of two differences
  localparam int SUM_W      = PROD_W + 2;           // sum of three products
  localparam int CROSS_W    = PROD_W + 1;           // cross product component
  localparam int MAG_W      = PROD_W - 1;           // |cross component|
  localparam int LO_W       = MAG_W / 2;            // low half of a magnitude
  localparam int HI_W       = MAG_W - LO_W;         // high half of a magnitude
  localparam int QUO_W      = PROD_W;               // squared distance (quotient)
  localparam int DEN_W      = PROD_W + 1;           // |d|^2
  localparam int NUM_W      = QUO_W + DEN_W + 1;    // |w x d|^2 and divider remainder
  localparam int ROOT_STEPS = QUO_W / 2;            // one result bit per root step
  localparam int DIST_W     = ROOT_STEPS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } coord3_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff3_t;

  function automatic logic signed [DIFF_W-1:0] sub_ext(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
  endfunction

  function automatic logic signed [PROD_W-1:0] mul_s(
    input logic signed [DIFF_W-1:0] a,
    input logic signed [DIFF_W-1:0] b
  );
    logic signed [PROD_W-1:0] ae;
    logic signed [PROD_W-1:0] be;
    ae = PROD_W'(a);
    be = PROD_W'(b);
    return ae * be;
  endfunction

endpackage

// ===== rtl/core/point_segment_distance.sv =====
`timescale 1ns / 1ps

// Point to 3D segment distance, fixed point with 8 fraction bits.
//
// Input channel: the segment start, end and query point are taken at a
// rising clock edge where start_i is high and busy_o is low. busy_o is
// always low here, so one item can be issued every cycle.
// Result channel: valid_o is high for exactly one cycle with distance_o
// (unsigned, 8 fraction bits, truncated). Results come out in issue order.
//
// Throughput is one item per cycle. The depth is set by the
// restoring divider (one quotient bit per stage, 50 stages) that forms
// |w x d|^2 / |d|^2, and the digit-by-digit square root behind it (one
// result bit per stage, 25 stages). Seven front stages do the differences,
// 25x25 products, sums, case select and split squaring of the cross terms.
//
// Reset clears all stage valid bits; items in flight are dropped. The
// receiver cannot stall, so the pipeline never holds.
module point_segment_distance import psd_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] end_z_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  output logic                         valid_o,
  output logic [DIST_W-1:0]            distance_o
);

  // ---------------- front stages ----------------
  logic    v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  coord3_t st_q, en_q, qu_q;

  diff3_t  d_q, w_q, u_q;   // d = end-start, w = query-start, u = query-end

  logic signed [PROD_W-1:0] pdot_q [3];
  logic signed [PROD_W-1:0] plen_q [3];
  logic signed [PROD_W-1:0] pw_q   [3];
  logic signed [PROD_W-1:0] pu_q   [3];
  logic signed [PROD_W-1:0] pc_q   [6];

  logic signed [SUM_W-1:0]   dot_q, len2_q, nw_q, nu_q;
  logic signed [CROSS_W-1:0] cr_q [3];

  logic                  mid5_q;
  logic [QUO_W-1:0]      simple5_q;
  logic [DEN_W-1:0]      den5_q;
  logic [MAG_W-1:0]      cmag_q [3];

  logic                  mid6_q;
  logic [QUO_W-1:0]      simple6_q;
  logic [DEN_W-1:0]      den6_q;
  logic [2*HI_W-1:0]     hh_q [3];
  logic [HI_W+LO_W-1:0]  hl_q [3];
  logic [2*LO_W-1:0]     ll_q [3];

  // stage 5 select
  logic signed [CROSS_W-1:0] cr_abs [3];
  logic                      lo_case, hi_case;

  // stage 6 -> divider entry
  logic [NUM_W-1:0] csq [3];
  logic [NUM_W-1:0] num_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_abs[i] = cr_q[i][CROSS_W-1] ? -cr_q[i] : cr_q[i];
    end
    lo_case = dot_q[SUM_W-1] || (dot_q == '0);
    hi_case = (dot_q >= len2_q);
    for (int i = 0; i < 3; i++) begin
      csq[i] = (NUM_W'(hh_q[i]) << (2 * LO_W)) + (NUM_W'(hl_q[i]) << (LO_W + 1))
             + NUM_W'(ll_q[i]);
    end
    num_sum = csq[0] + csq[1] + csq[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= '{x: start_x_i, y: start_y_i, z: start_z_i};
    en_q <= '{x: end_x_i,   y: end_y_i,   z: end_z_i};
    qu_q <= '{x: query_x_i, y: query_y_i, z: query_z_i};

    d_q.x <= sub_ext(en_q.x, st_q.x);
    d_q.y <= sub_ext(en_q.y, st_q.y);
    d_q.z <= sub_ext(en_q.z, st_q.z);
    w_q.x <= sub_ext(qu_q.x, st_q.x);
    w_q.y <= sub_ext(qu_q.y, st_q.y);
    w_q.z <= sub_ext(qu_q.z, st_q.z);
    u_q.x <= sub_ext(qu_q.x, en_q.x);
    u_q.y <= sub_ext(qu_q.y, en_q.y);
    u_q.z <= sub_ext(qu_q.z, en_q.z);

    pdot_q[0] <= mul_s(w_q.x, d_q.x);
    pdot_q[1] <= mul_s(w_q.y, d_q.y);
    pdot_q[2] <= mul_s(w_q.z, d_q.z);
    plen_q[0] <= mul_s(d_q.x, d_q.x);
    plen_q[1] <= mul_s(d_q.y, d_q.y);
    plen_q[2] <= mul_s(d_q.z, d_q.z);
    pw_q[0]   <= mul_s(w_q.x, w_q.x);
    pw_q[1]   <= mul_s(w_q.y, w_q.y);
    pw_q[2]   <= mul_s(w_q.z, w_q.z);
    pu_q[0]   <= mul_s(u_q.x, u_q.x);
    pu_q[1]   <= mul_s(u_q.y, u_q.y);
    pu_q[2]   <= mul_s(u_q.z, u_q.z);
    pc_q[0]   <= mul_s(w_q.y, d_q.z);
    pc_q[1]   <= mul_s(w_q.z, d_q.y);
    pc_q[2]   <= mul_s(w_q.z, d_q.x);
    pc_q[3]   <= mul_s(w_q.x, d_q.z);
    pc_q[4]   <= mul_s(w_q.x, d_q.y);
    pc_q[5]   <= mul_s(w_q.y, d_q.x);

    dot_q  <= SUM_W'(pdot_q[0]) + SUM_W'(pdot_q[1]) + SUM_W'(pdot_q[2]);
    len2_q <= SUM_W'(plen_q[0]) + SUM_W'(plen_q[1]) + SUM_W'(plen_q[2]);
    nw_q   <= SUM_W'(pw_q[0]) + SUM_W'(pw_q[1]) + SUM_W'(pw_q[2]);
    nu_q   <= SUM_W'(pu_q[0]) + SUM_W'(pu_q[1]) + SUM_W'(pu_q[2]);
    cr_q[0] <= CROSS_W'(pc_q[0]) - CROSS_W'(pc_q[1]);
    cr_q[1] <= CROSS_W'(pc_q[2]) - CROSS_W'(pc_q[3]);
    cr_q[2] <= CROSS_W'(pc_q[4]) - CROSS_W'(pc_q[5]);

    // case select: nearest point is start, end, or interior
    mid5_q    <= !lo_case && !hi_case;
    simple5_q <= lo_case ? nw_q[QUO_W-1:0] : nu_q[QUO_W-1:0];
    den5_q    <= len2_q[DEN_W-1:0];
    for (int i = 0; i < 3; i++) begin
      cmag_q[i] <= cr_abs[i][MAG_W-1:0];
    end

    // split squaring: |c|^2 = hh*2^(2L) + 2*hl*2^L + ll
    mid6_q    <= mid5_q;
    simple6_q <= simple5_q;
    den6_q    <= den5_q;
    for (int i = 0; i < 3; i++) begin
      hh_q[i] <= cmag_q[i][MAG_W-1:LO_W] * cmag_q[i][MAG_W-1:LO_W];
      hl_q[i] <= cmag_q[i][MAG_W-1:LO_W] * cmag_q[i][LO_W-1:0];
      ll_q[i] <= cmag_q[i][LO_W-1:0] * cmag_q[i][LO_W-1:0];
    end
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  logic                 div_v_q   [QUO_W+1];
  logic [NUM_W-1:0]     div_rem_q [QUO_W+1];
  logic [DEN_W-1:0]     div_den_q [QUO_W+1];
  logic [QUO_W-1:0]     div_quo_q [QUO_W+1];
  logic [NUM_W-1:0]     div_trial [QUO_W];
  logic                 div_ge    [QUO_W];

  always_comb begin
    for (int i = 0; i < QUO_W; i++) begin
      div_trial[i] = NUM_W'(div_den_q[i]) << (QUO_W - 1 - i);
      div_ge[i]    = (div_rem_q[i] >= div_trial[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QUO_W; i++) begin
        div_v_q[i] <= 1'b0;
      end
    end else begin
      div_v_q[0] <= v6_q;
      for (int i = 0; i < QUO_W; i++) begin
        div_v_q[i+1] <= div_v_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // end cases divide by one
    div_rem_q[0] <= mid6_q ? num_sum : NUM_W'(simple6_q);
    div_den_q[0] <= mid6_q ? den6_q : DEN_W'(1);
    div_quo_q[0] <= '0;
    for (int i = 0; i < QUO_W; i++) begin
      div_rem_q[i+1] <= div_ge[i] ? div_rem_q[i] - div_trial[i] : div_rem_q[i];
      div_den_q[i+1] <= div_den_q[i];
      div_quo_q[i+1] <= {div_quo_q[i][QUO_W-2:0], div_ge[i]};
    end
  end

  // ---------------- integer square root, one result bit per stage ----------------
  logic               sq_v_q   [1:ROOT_STEPS];
  logic [QUO_W-1:0]   sq_op_q  [1:ROOT_STEPS];
  logic [QUO_W:0]     sq_res_q [1:ROOT_STEPS];

  logic [QUO_W-1:0]   sq_op_in  [ROOT_STEPS];
  logic [QUO_W:0]     sq_res_in [ROOT_STEPS];
  logic [QUO_W:0]     sq_one    [ROOT_STEPS];
  logic [QUO_W:0]     sq_test   [ROOT_STEPS];
  logic               sq_ge     [ROOT_STEPS];

  always_comb begin
    for (int j = 0; j < ROOT_STEPS; j++) begin
      if (j == 0) begin
        sq_op_in[j]  = div_quo_q[QUO_W];
        sq_res_in[j] = '0;
      end else begin
        sq_op_in[j]  = sq_op_q[j];
        sq_res_in[j] = sq_res_q[j];
      end
      sq_one[j]  = (QUO_W + 1)'(1) << (2 * (ROOT_STEPS - 1 - j));
      sq_test[j] = sq_res_in[j] + sq_one[j];
      sq_ge[j]   = ({1'b0, sq_op_in[j]} >= sq_test[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 1; j <= ROOT_STEPS; j++) begin
        sq_v_q[j] <= 1'b0;
      end
    end else begin
      sq_v_q[1] <= div_v_q[QUO_W];
      for (int j = 1; j < ROOT_STEPS; j++) begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ROOT_STEPS; j++) begin
      sq_op_q[j+1]  <= sq_ge[j] ? QUO_W'(sq_op_in[j] - sq_test[j][QUO_W-1:0])
                                : sq_op_in[j];
      sq_res_q[j+1] <= sq_ge[j] ? (sq_res_in[j] >> 1) + sq_one[j]
                                : (sq_res_in[j] >> 1);
    end
  end

  assign busy_o     = 1'b0;
  assign valid_o    = sq_v_q[ROOT_STEPS];
  assign distance_o = sq_res_q[ROOT_STEPS][DIST_W-1:0];

endmodule
